[sv/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/prt_pkg.sv]
`timescale 1ns / 1ps

package prt_pkg;

  localparam int COORD_W = 24;
  localparam int QUAT_W  = 16;
  localparam int SHIFT_W = 32;
  localparam int PROD_W  = 32;
  localparam int MAT_W   = 34;
  localparam int TERM_W  = MAT_W + COORD_W;
  localparam int ACC_W   = TERM_W + 2;
  localparam int FRAC_W  = 28;
  localparam int WORLD_W = 32;
  localparam int IDX_W   = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic signed [PROD_W-1:0]  qprod_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [WORLD_W-1:0] world_t;
  typedef logic [IDX_W-1:0]          reg_idx_t;

  localparam reg_idx_t REG_QUAT_X  = 3'd0;
  localparam reg_idx_t REG_QUAT_Y  = 3'd1;
  localparam reg_idx_t REG_QUAT_Z  = 3'd2;
  localparam reg_idx_t REG_QUAT_W  = 3'd3;
  localparam reg_idx_t REG_SHIFT_X = 3'd4;
  localparam reg_idx_t REG_SHIFT_Y = 3'd5;
  localparam reg_idx_t REG_SHIFT_Z = 3'd6;

  localparam quat_t  QUAT_ONE  = 16'sh4000;
  localparam mat_t   ONE_Q28   = 34'sh0_1000_0000;
  localparam acc_t   HALF_Q28  = 60'sh0_0000_0000_0800_0000;
  localparam world_t WORLD_MAX = 32'sh7FFF_FFFF;
  localparam world_t WORLD_MIN = 32'sh8000_0000;

endpackage

[sv/point_rigid_transform.sv]
// Channel   Dir  Beat fields (low bit up)                  Handshake
// s_axis    in   tdata: point_x, point_y, point_z; tlast   tvalid / tready
// m_axis    out  tdata: world_x, world_y, world_z; tlast   tvalid / tready
// cfg       in   cfg_addr (register index), cfg_data      cfg_valid / cfg_ready
//
// Throughput is one point per cycle unless the output stalls.
// Stages: capture, hold, 34x24 products, three-way sum, round + shift + saturate.
// Rotation matrix is built from the quaternion in two free-running stages,
// ready before a point accepted after a register write reaches the products.
// Reset is synchronous; it restores the identity pose and empties the pipe.
// A stalled output freezes every point stage; s_axis_tready follows that stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module point_rigid_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [71:0]                  s_axis_tdata,  // point_x, point_y, point_z
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [95:0]                  m_axis_tdata,  // world_x, world_y, world_z
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  prt_pkg::reg_idx_t            cfg_addr,
  input  logic [prt_pkg::SHIFT_W-1:0]  cfg_data
);

  import prt_pkg::*;

  quat_t  quat_x, quat_y, quat_z, quat_w;
  shift_t shift [3];

  qprod_t qxx, qyy, qzz, qxy, qxz, qyz, qxw, qyw, qzw;
  mat_t   mat [3][3];

  logic   en;
  logic   v1, v2, v3, v4, v5;
  logic   l1, l2, l3, l4, l5;
  coord_t pt1 [3];
  coord_t pt2 [3];
  term_t  prod [3][3];
  acc_t   acc [3];
  world_t world [3];
  world_t world_next [3];
  logic signed [WORLD_W:0] tot [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_ONE;
      for (int i = 0; i < 3; i++) shift[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_QUAT_X:  quat_x   <= cfg_data[QUAT_W-1:0];
        REG_QUAT_Y:  quat_y   <= cfg_data[QUAT_W-1:0];
        REG_QUAT_Z:  quat_z   <= cfg_data[QUAT_W-1:0];
        REG_QUAT_W:  quat_w   <= cfg_data[QUAT_W-1:0];
        REG_SHIFT_X: shift[0] <= cfg_data;
        REG_SHIFT_Y: shift[1] <= cfg_data;
        REG_SHIFT_Z: shift[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Matrix build: quaternion products, then entries in Q28.
  always_ff @(posedge clk) begin
    if (rst) begin
      {qxx, qyy, qzz, qxy, qxz, qyz, qxw, qyw, qzw} <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) mat[i][j] <= (i == j) ? ONE_Q28 : '0;
      end
    end else begin
      qxx <= quat_x * quat_x;
      qyy <= quat_y * quat_y;
      qzz <= quat_z * quat_z;
      qxy <= quat_x * quat_y;
      qxz <= quat_x * quat_z;
      qyz <= quat_y * quat_z;
      qxw <= quat_x * quat_w;
      qyw <= quat_y * quat_w;
      qzw <= quat_z * quat_w;
      mat[0][0] <= ONE_Q28 - ((MAT_W'(qyy) + MAT_W'(qzz)) <<< 1);
      mat[0][1] <= (MAT_W'(qxy) - MAT_W'(qzw)) <<< 1;
      mat[0][2] <= (MAT_W'(qxz) + MAT_W'(qyw)) <<< 1;
      mat[1][0] <= (MAT_W'(qxy) + MAT_W'(qzw)) <<< 1;
      mat[1][1] <= ONE_Q28 - ((MAT_W'(qxx) + MAT_W'(qzz)) <<< 1);
      mat[1][2] <= (MAT_W'(qyz) - MAT_W'(qxw)) <<< 1;
      mat[2][0] <= (MAT_W'(qxz) - MAT_W'(qyw)) <<< 1;
      mat[2][1] <= (MAT_W'(qyz) + MAT_W'(qxw)) <<< 1;
      mat[2][2] <= ONE_Q28 - ((MAT_W'(qxx) + MAT_W'(qyy)) <<< 1);
    end
  end

  assign en            = !v5 || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (WORLD_W + 1)'($signed(acc[i][ACC_W-1:FRAC_W]))
               + (WORLD_W + 1)'(shift[i]);
      if (tot[i][WORLD_W] != tot[i][WORLD_W-1]) begin
        world_next[i] = tot[i][WORLD_W] ? WORLD_MIN : WORLD_MAX;
      end else begin
        world_next[i] = tot[i][WORLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt1[i] <= s_axis_tdata[i*COORD_W +: COORD_W];
        pt2[i] <= pt1[i];
        for (int j = 0; j < 3; j++) prod[i][j] <= TERM_W'(mat[i][j] * pt2[j]);
        acc[i] <= ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2])
                  + HALF_Q28;
        world[i] <= world_next[i];
      end
      l1 <= s_axis_tlast;
      l2 <= l1;
      l3 <= l2;
      l4 <= l3;
      l5 <= l4;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {world[2], world[1], world[0]};
  assign m_axis_tlast  = l5;

  `CHK_NEXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, v1,
            "accepted beat missing from first stage")
  `CHK_NEXT(a_stall_freezes, clk, rst, !en, $stable({v1, v2, v3, v4, v5}),
            "pipeline moved during a stall")
  `CHK_NEXT(a_last_stage_moves, clk, rst, v4 && en, v5,
            "beat lost between sum and output stage")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import prt_pkg::*;

  localparam reg_idx_t REG_NONE = 3'd7;
  localparam longint Q28_ONE = 64'sd268435456;
  localparam longint Q28_HALF = 64'sd134217728;
  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = 24'sh800000;

  typedef struct packed {
    world_t x;
    world_t y;
    world_t z;
    logic   last;
  } world_pt_t;

  typedef enum logic [1:0] {ROW_POINT, ROW_POINT_CHK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    coord_t      px;
    coord_t      py;
    coord_t      pz;
    logic        last;
    world_t      ex;
    world_t      ey;
    world_t      ez;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // point_x, point_y, point_z
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;       // world_x, world_y, world_z
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_addr = REG_QUAT_X;
  logic [SHIFT_W-1:0] cfg_data = '0;

  point_rigid_transform i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  quat_t pose_qx = '0;
  quat_t pose_qy = '0;
  quat_t pose_qz = '0;
  quat_t pose_qw = QUAT_ONE;
  shift_t pose_shift [3] = '{'0, '0, '0};

  world_pt_t results_due [$];
  stim_row_t rows [$];
  int fail_count = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int src_pct [4] = '{0, 56, 0, 11};
  int snk_pct [4] = '{0, 0, 56, 11};
  logic drv_typed = 1'b0;
  world_pt_t drv_exp = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= snk_stall);
  end

  function automatic world_pt_t rotate_translate(coord_t px, coord_t py, coord_t pz,
                                                 logic last);
    longint x, y, z, w, acc;
    longint r [9];
    longint p [3];
    world_t v [3];
    x = pose_qx;
    y = pose_qy;
    z = pose_qz;
    w = pose_qw;
    r[0] = Q28_ONE - 2 * (y * y + z * z);
    r[1] = 2 * (x * y - z * w);
    r[2] = 2 * (x * z + y * w);
    r[3] = 2 * (x * y + z * w);
    r[4] = Q28_ONE - 2 * (x * x + z * z);
    r[5] = 2 * (y * z - x * w);
    r[6] = 2 * (x * z - y * w);
    r[7] = 2 * (y * z + x * w);
    r[8] = Q28_ONE - 2 * (x * x + y * y);
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int a = 0; a < 3; a++) begin
      acc = r[3*a] * p[0] + r[3*a+1] * p[1] + r[3*a+2] * p[2];
      acc = ((acc + Q28_HALF) >>> FRAC_W) + longint'(pose_shift[a]);
      if (acc > longint'(WORLD_MAX)) v[a] = WORLD_MAX;
      else if (acc < longint'(WORLD_MIN)) v[a] = WORLD_MIN;
      else v[a] = world_t'(acc);
    end
    return '{v[0], v[1], v[2], last};
  endfunction

  always @(posedge clk) begin : scoreboard
    world_pt_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tlast};
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: x=%0d y=%0d z=%0d last=%0b",
                     got.x, got.y, got.z, got.last);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("world mismatch: exp x=%0d y=%0d z=%0d last=%0b | got x=%0d y=%0d z=%0d last=%0b",
                       want.x, want.y, want.z, want.last, got.x, got.y, got.z, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_QUAT_X:  pose_qx = cfg_data[15:0];
          REG_QUAT_Y:  pose_qy = cfg_data[15:0];
          REG_QUAT_Z:  pose_qz = cfg_data[15:0];
          REG_QUAT_W:  pose_qw = cfg_data[15:0];
          REG_SHIFT_X: pose_shift[0] = cfg_data;
          REG_SHIFT_Y: pose_shift[1] = cfg_data;
          REG_SHIFT_Z: pose_shift[2] = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (drv_typed)
          results_due.push_back(drv_exp);
        else
          results_due.push_back(rotate_translate(s_axis_tdata[23:0], s_axis_tdata[47:24],
                                                 s_axis_tdata[71:48], s_axis_tlast));
      end
    end
  end

  task automatic send_point(coord_t px, coord_t py, coord_t pz, logic last,
                            logic typed, world_pt_t want);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {pz, py, px};
    s_axis_tlast = last;
    drv_typed = typed;
    drv_exp = want;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  function automatic void add_reg(reg_idx_t idx, logic [31:0] value);
    rows.push_back('{ROW_REG, idx, value, '0, '0, '0, 1'b0, '0, '0, '0});
  endfunction

  function automatic void add_pt(coord_t px, coord_t py, coord_t pz, logic last);
    rows.push_back('{ROW_POINT, REG_NONE, '0, px, py, pz, last, '0, '0, '0});
  endfunction

  function automatic void add_pt_chk(coord_t px, coord_t py, coord_t pz, logic last,
                                     world_t ex, world_t ey, world_t ez);
    rows.push_back('{ROW_POINT_CHK, REG_NONE, '0, px, py, pz, last, ex, ey, ez});
  endfunction

  function automatic logic [31:0] rand_quat();
    quat_t q;
    case ($urandom_range(3))
      0: q = quat_t'($urandom);
      3: q = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: q = quat_t'(int'($urandom_range(32768)) - 16384);
    endcase
    return {16'($urandom), q};
  endfunction

  function automatic logic [31:0] rand_shift();
    case ($urandom_range(3))
      0: return $urandom;
      3: return $urandom_range(1) ? WORLD_MAX : WORLD_MIN;
      default: return int'($urandom_range(2097152)) - 1048576;
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'(int'($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  initial begin
    // identity pose after reset
    add_pt_chk(0, 0, 0, 1'b0, 0, 0, 0);
    add_pt_chk(C_MAX, C_MAX, C_MAX, 1'b1, 8388607, 8388607, 8388607);
    add_pt_chk(C_MIN, C_MIN, C_MIN, 1'b0, -8388608, -8388608, -8388608);
    add_pt_chk(24'sh555555, 24'shAAAAAA, 1, 1'b1, 5592405, -5592406, 1);
    // translation extremes, saturate both ways
    add_reg(REG_SHIFT_X, 32'h7FFF_FFFF);
    add_reg(REG_SHIFT_Y, 32'h8000_0000);
    add_reg(REG_SHIFT_Z, 32'h0000_0001);
    add_pt_chk(C_MAX, C_MIN, 0, 1'b0, WORLD_MAX, WORLD_MIN, 1);
    add_pt_chk(C_MIN, C_MAX, -1, 1'b1, 2139095039, -2139095041, 0);
    // unmapped index must leave the pose alone
    add_reg(REG_SHIFT_X, 32'h0);
    add_reg(REG_SHIFT_Y, 32'h0);
    add_reg(REG_SHIFT_Z, 32'h0);
    add_reg(REG_NONE, 32'h1234_5678);
    add_pt_chk(100, 200, 300, 1'b0, 100, 200, 300);
    // zero quaternion gives identity
    add_reg(REG_QUAT_W, 32'h0);
    add_pt_chk(12345, -54321, 777, 1'b1, 12345, -54321, 777);
    // half turn about z
    add_reg(REG_QUAT_Z, 32'h0000_4000);
    add_pt_chk(1000, 2000, 3000, 1'b0, -1000, -2000, 3000);
    // most negative component
    add_reg(REG_QUAT_X, 32'h0000_8000);
    add_reg(REG_QUAT_Z, 32'h0);
    add_pt(C_MAX, C_MIN, C_MAX, 1'b1);
    add_pt(C_MIN, C_MAX, 5, 1'b0);
    // non-unit quaternion
    add_reg(REG_QUAT_X, 32'h0000_4000);
    add_reg(REG_QUAT_Y, 32'h0000_4000);
    add_reg(REG_QUAT_Z, 32'h0000_4000);
    add_reg(REG_QUAT_W, 32'h0000_4000);
    add_pt(1024, -2048, 4096, 1'b0);
    add_pt(C_MAX, C_MAX, C_MIN, 1'b1);
    add_reg(REG_QUAT_X, 32'h0000_7FFF);
    add_reg(REG_QUAT_Y, 32'h0000_7FFF);
    add_reg(REG_QUAT_Z, 32'h0000_7FFF);
    add_reg(REG_QUAT_W, 32'h0000_7FFF);
    add_pt(C_MIN, C_MIN, C_MIN, 1'b0);
    add_reg(REG_QUAT_X, 32'hFFFF_8000);
    add_reg(REG_QUAT_Y, 32'hFFFF_8000);
    add_reg(REG_QUAT_Z, 32'hFFFF_8000);
    add_reg(REG_QUAT_W, 32'hFFFF_8000);
    add_pt(C_MAX, C_MIN, C_MAX, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        drain();
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].last,
                   rows[i].kind == ROW_POINT_CHK,
                   '{rows[i].ex, rows[i].ey, rows[i].ez, rows[i].last});
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      src_idle = src_pct[phase % 4];
      snk_stall = snk_pct[phase % 4];
      write_reg(REG_QUAT_X, rand_quat());
      write_reg(REG_QUAT_Y, rand_quat());
      write_reg(REG_QUAT_Z, rand_quat());
      write_reg(REG_QUAT_W, rand_quat());
      write_reg(REG_SHIFT_X, rand_shift());
      write_reg(REG_SHIFT_Y, rand_shift());
      write_reg(REG_SHIFT_Z, rand_shift());
      if ($urandom_range(1)) write_reg(REG_NONE, $urandom);
      for (int n = 0; n < 56; n++) begin
        // hold the source until the pipe has emptied
        if (phase == 2 && n == 28) drain();
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0,
                   1'b0, '0);
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
